// File: design/mcet_pkg.sv
// Shared types and constants for the multi-channel event timer table.
// No dependencies; imported by the slot store, the adder and the top level.
package mcet_pkg;

  localparam int NOW_W    = 64;
  localparam int IVAL_W   = 32;
  localparam int EVT_W    = 32;
  localparam int OWNER_W  = 8;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;
  localparam int KIND_W   = 2;
  localparam int FIELD_SLOT_W = 6;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 56;

  // x/10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  localparam logic [IVAL_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;
  localparam int DELAY_W = 2 * IVAL_W - DIV10_SHIFT;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADIDX  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNUSED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RUNNING = 3'd4;
  localparam logic [STAT_W-1:0] ST_STOPPED = 3'd5;

  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RAISE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Control from the sequencer to the slot store
  typedef struct packed {
    logic owner_we;
    logic timer_we;
    logic rd_en;
  } mcet_mem_ctl_t;

endpackage

// File: design/multi_channel_event_timer_table.sv
// Event timer table: TIMER_COUNT slots served by one command per input transfer,
// each command answered by zero or more event results and one status reply
// with tlast set. The block takes one command at a time. Enable does a
// reciprocal multiply, then the shared 64-bit adder forms the saturating
// deadline; a request scans the occupied slots up to the first free one; a
// tick visits every slot and, for each running slot, does a slot-memory read
// and then the compare on the shared adder. Backpressure on the result
// channel stalls the block.
module multi_channel_event_timer_table
  import mcet_pkg::*;
#(
  parameter int TIMER_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [5:0] timer_index, [37:6] interval_ms, [69:38] event_mask,
  // [77:70] task_id, [141:78] now_ticks, [143:142] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [8:3] slot, [16:9] owner_task, [48:17] events, [55:49] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int SLOT_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [FIELD_SLOT_W-1:0] COUNT_F = FIELD_SLOT_W'(TIMER_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_REQ    = 3'd2;
  localparam logic [2:0] S_EN_ADD = 3'd3;
  localparam logic [2:0] S_TICK   = 3'd4;
  localparam logic [2:0] S_TICK_C = 3'd5;
  localparam logic [2:0] S_CLR    = 3'd6;
  localparam logic [2:0] S_REPLY  = 3'd7;

  logic [2:0] state_r, state_nxt;

  // latched command
  logic [CMD_W-1:0]        cmd_r;
  logic [FIELD_SLOT_W-1:0] index_r;
  logic [IVAL_W-1:0]       interval_r;
  logic [EVT_W-1:0]        mask_r;
  logic [OWNER_W-1:0]      task_r;
  logic [NOW_W-1:0]        now_r;

  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic [DELAY_W-1:0]      delay_r, delay_nxt;
  logic [2*IVAL_W-1:0]     prod_full;

  logic [TIMER_COUNT-1:0]  in_use_r, in_use_nxt;
  logic [TIMER_COUNT-1:0]  running_r, running_nxt;

  logic [STAT_W-1:0]       rep_status_r, rep_status_nxt;
  logic [FIELD_SLOT_W-1:0] rep_slot_r, rep_slot_nxt;
  logic [OWNER_W-1:0]      rep_owner_r, rep_owner_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [FIELD_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [OWNER_W-1:0]      out_owner_r, out_owner_nxt;
  logic [EVT_W-1:0]        out_events_r, out_events_nxt;
  logic                    out_last_r, out_last_nxt;

  mcet_mem_ctl_t           mem_ctl;
  logic [OWNER_W-1:0]      owner_rdata;
  logic [EVT_W-1:0]        events_rdata;
  logic [NOW_W-1:0]        deadline_rdata;
  logic [NOW_W-1:0]        deadline_wdata;

  logic [NOW_W-1:0]        add_b, add_sum;
  logic                    add_cin, add_cout;
  logic                    out_free;
  logic [SLOT_W-1:0]       index_slot;
  logic [SLOT_W-1:0]       mem_addr;

  // the addressed slot is read straight from the command while it is decoded
  assign mem_addr = (state_r == S_START) ? index_slot : idx_r;

  mcet_store #(
    .DEPTH (TIMER_COUNT),
    .AW    (SLOT_W)
  ) u_store (
    .clk            (clk),
    .ctl            (mem_ctl),
    .addr           (mem_addr),
    .owner_wdata    (task_r),
    .events_wdata   (mask_r),
    .deadline_wdata (deadline_wdata),
    .owner_rdata    (owner_rdata),
    .events_rdata   (events_rdata),
    .deadline_rdata (deadline_rdata)
  );

  // Shared unit: now + delay on enable, now + ~deadline + 1 on tick
  assign add_b   = (state_r == S_EN_ADD) ? {{(NOW_W-DELAY_W){1'b0}}, delay_r}
                                         : ~deadline_rdata;
  assign add_cin = (state_r != S_EN_ADD);

  mcet_add64 u_add (
    .a    (now_r),
    .b    (add_b),
    .cin  (add_cin),
    .sum  (add_sum),
    .cout (add_cout)
  );

  assign deadline_wdata = add_cout ? {NOW_W{1'b1}} : add_sum;
  assign prod_full      = interval_r * DIV10_RECIP;
  assign index_slot     = index_r[SLOT_W-1:0];
  assign out_free       = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-49){1'b0}}, out_events_r, out_owner_r,
                       out_slot_r, out_status_r};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    delay_nxt      = delay_r;
    in_use_nxt     = in_use_r;
    running_nxt    = running_r;
    rep_status_nxt = rep_status_r;
    rep_slot_nxt   = rep_slot_r;
    rep_owner_nxt  = rep_owner_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_owner_nxt  = out_owner_r;
    out_events_nxt = out_events_r;
    out_last_nxt   = out_last_r;
    mem_ctl        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        rep_status_nxt = ST_OK;
        rep_slot_nxt   = '0;
        rep_owner_nxt  = '0;
        idx_nxt        = '0;
        state_nxt      = S_REPLY;
        if (cmd_r == CMD_REQUEST) begin
          state_nxt = S_REQ;
        end else if (cmd_r == CMD_TICK) begin
          state_nxt = S_TICK;
        end else if (cmd_r > CMD_TICK) begin
          state_nxt = S_REPLY;
        end else if (index_r >= COUNT_F) begin
          rep_status_nxt = ST_BADIDX;
        end else if (!in_use_r[index_slot]) begin
          rep_status_nxt = ST_UNUSED;
        end else begin
          idx_nxt = index_slot;
          case (cmd_r) inside
            CMD_ENABLE: begin
              delay_nxt = prod_full[2*IVAL_W-1:DIV10_SHIFT];
              state_nxt = S_EN_ADD;
            end
            CMD_DISABLE, CMD_RELEASE: begin
              if (cmd_r == CMD_RELEASE) begin
                in_use_nxt[index_slot] = 1'b0;
              end
              if (running_r[index_slot]) begin
                mem_ctl.rd_en = 1'b1;
                state_nxt     = S_CLR;
              end
            end
            default: begin
              rep_status_nxt = running_r[index_slot] ? ST_RUNNING : ST_STOPPED;
            end
          endcase
        end
      end

      // lowest free slot, one slot per cycle
      S_REQ: begin
        if (!in_use_r[idx_r]) begin
          in_use_nxt[idx_r]  = 1'b1;
          running_nxt[idx_r] = 1'b0;
          mem_ctl.owner_we   = 1'b1;
          rep_slot_nxt       = FIELD_SLOT_W'(idx_r);
          rep_owner_nxt      = task_r;
          state_nxt          = S_REPLY;
        end else if (idx_r == LAST_SLOT) begin
          rep_status_nxt = ST_FULL;
          state_nxt      = S_REPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EN_ADD: begin
        mem_ctl.timer_we   = 1'b1;
        running_nxt[idx_r] = 1'b1;
        state_nxt          = S_REPLY;
      end

      S_TICK: begin
        if (in_use_r[idx_r] && running_r[idx_r]) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = S_TICK_C;
        end else if (idx_r == LAST_SLOT) begin
          state_nxt = S_REPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // carry out of now + ~deadline + 1 means now >= deadline
      S_TICK_C: begin
        if (!add_cout || out_free) begin
          if (add_cout) begin
            running_nxt[idx_r] = 1'b0;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_RAISE;
            out_status_nxt = ST_OK;
            out_slot_nxt   = FIELD_SLOT_W'(idx_r);
            out_owner_nxt  = owner_rdata;
            out_events_nxt = events_rdata;
            out_last_nxt   = 1'b0;
          end
          if (idx_r == LAST_SLOT) begin
            state_nxt = S_REPLY;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TICK;
          end
        end
      end

      S_CLR: begin
        if (out_free) begin
          running_nxt[idx_r] = 1'b0;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_CLEAR;
          out_status_nxt = ST_OK;
          out_slot_nxt   = FIELD_SLOT_W'(idx_r);
          out_owner_nxt  = owner_rdata;
          out_events_nxt = events_rdata;
          out_last_nxt   = 1'b0;
          state_nxt      = S_REPLY;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_REPLY;
          out_status_nxt = rep_status_r;
          out_slot_nxt   = rep_slot_r;
          out_owner_nxt  = rep_owner_r;
          out_events_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r      <= in_tuser;
      index_r    <= in_tdata[5:0];
      interval_r <= in_tdata[37:6];
      mask_r     <= in_tdata[69:38];
      task_r     <= in_tdata[77:70];
      now_r      <= in_tdata[141:78];
    end
    idx_r        <= idx_nxt;
    delay_r      <= delay_nxt;
    rep_status_r <= rep_status_nxt;
    rep_slot_r   <= rep_slot_nxt;
    rep_owner_r  <= rep_owner_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_owner_r  <= out_owner_nxt;
    out_events_r <= out_events_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// File: design/mcet_add64.sv
// Shared 64-bit adder with carry out: deadline sum and expiry compare.
// Depends on mcet_pkg.
module mcet_add64
  import mcet_pkg::*;
(
  input  logic [NOW_W-1:0] a,
  input  logic [NOW_W-1:0] b,
  input  logic             cin,
  output logic [NOW_W-1:0] sum,
  output logic             cout
);

  logic [NOW_W:0] full;

  assign full = {1'b0, a} + {1'b0, b} + {{NOW_W{1'b0}}, cin};
  assign sum  = full[NOW_W-1:0];
  assign cout = full[NOW_W];

endmodule

// File: design/mcet_store.sv
// Per-slot payload memory: owner task, event mask and deadline.
// One write address, one registered read port. Depends on mcet_pkg.
module mcet_store
  import mcet_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  mcet_mem_ctl_t       ctl,
  input  logic [AW-1:0]       addr,
  input  logic [OWNER_W-1:0]  owner_wdata,
  input  logic [EVT_W-1:0]    events_wdata,
  input  logic [NOW_W-1:0]    deadline_wdata,
  output logic [OWNER_W-1:0]  owner_rdata,
  output logic [EVT_W-1:0]    events_rdata,
  output logic [NOW_W-1:0]    deadline_rdata
);

  logic [OWNER_W-1:0] owner_mem    [DEPTH];
  logic [EVT_W-1:0]   events_mem   [DEPTH];
  logic [NOW_W-1:0]   deadline_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.owner_we) begin
      owner_mem[addr] <= owner_wdata;
    end
    if (ctl.timer_we) begin
      events_mem[addr]   <= events_wdata;
      deadline_mem[addr] <= deadline_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      owner_rdata    <= owner_mem[addr];
      events_rdata   <= events_mem[addr];
      deadline_rdata <= deadline_mem[addr];
    end
  end

endmodule
